// File: rtl/core/scd_pkg.sv
// Shared types and constants for the sector cache directory.
package scd_pkg;

    localparam int DEFAULT_SLOTS = 16;

    localparam int KIND_W   = 2;
    localparam int SECTOR_W = 28;
    localparam int ACT_W    = 2;
    localparam int SLOT_W   = 4;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    // disk actions reported with each result
    localparam logic [ACT_W-1:0] ACT_NONE       = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE_BACK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FILL       = 2'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE_THRU = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WB_READ,
        ST_WB_EMIT,
        ST_FILL_EMIT,
        ST_HIT_EMIT,
        ST_FL_NEXT,
        ST_FL_EMIT,
        ST_FL_NONE
    } state_t;

endpackage

// File: rtl/core/scd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module scd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/sector_cache_directory.sv
// Sector cache directory: tag search, victim choice and flush sequencing.
//
// Tag and directory controller of a fully associative sector cache with
// SLOTS slots and round-robin replacement. Each request is a one-sector
// read, a one-sector write or a flush; results name the disk transfer to
// run (write-back, fill, write-through) or report a hit. Tags live in one
// RAM with a single read port and registered read data, so the tag
// search walks the slots one per cycle. A read or write gives one result,
// preceded by a write-back result when a dirty victim must be evicted. A
// flush gives one result per valid slot, or a single result with no action
// when no slot is valid. A request of the unused kind is dropped in the
// cycle it is taken. A new request is taken only while the sequencer is
// idle, but the result register lets the next request start while the last
// result still waits to be taken. The slot port carries the low four bits
// of the slot index.
module sector_cache_directory #(
    parameter int SLOTS = scd_pkg::DEFAULT_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [scd_pkg::KIND_W-1:0]    kind,
    input  logic [scd_pkg::SECTOR_W-1:0]  sector_number,
    input  logic                          drive,
    input  logic                          last_of_request,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [scd_pkg::ACT_W-1:0]     action,
    output logic [scd_pkg::SLOT_W-1:0]    slot,
    output logic [scd_pkg::SECTOR_W-1:0]  disk_sector,
    output logic                          disk_drive,
    output logic                          hit,
    output logic                          final_res,
    output logic                          request_done
);

    import scd_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // sequencer state
    state_t state_reg, state_next;

    // request held for the whole sequence
    logic [KIND_W-1:0]   kind_reg;
    logic [SECTOR_W-1:0] sec_reg;
    logic                req_drive_reg;
    logic                last_reg;

    // directory marks and replacement pointer
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] dirty_reg, dirty_next;
    logic [IDX_W-1:0] rp_reg, rp_next;

    // scan bookkeeping
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             cmp_live_reg, cmp_live_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [IDX_W-1:0] victim_reg, victim_next;
    logic             evict_reg, evict_next;

    // result register
    logic                rsp_valid_reg, rsp_valid_next;
    logic [ACT_W-1:0]    action_reg, action_next;
    logic [IDX_W-1:0]    slot_idx_reg, slot_idx_next;
    logic [SECTOR_W-1:0] sector_reg, sector_next;
    logic                drv_reg, drv_next;
    logic                hit_reg, hit_next;
    logic                final_reg, final_next;
    logic                done_reg, done_next;
    logic                load;

    // tag RAM ports
    logic                tag_wr_en;
    logic                tag_rd_en;
    logic [IDX_W-1:0]    tag_rd_addr;
    logic [SECTOR_W-1:0] tag_rd_data;

    logic                accept;
    logic                can_load;
    logic                valid_above;
    logic                free_now;
    logic [IDX_W+SLOT_W-1:0] slot_wide;

    scd_ram #(
        .WIDTH (SECTOR_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (victim_reg),
        .wr_data (sec_reg),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign can_load  = !rsp_valid_reg || !rsp_stall;

    // any valid slot beyond the one being flushed decides the last result
    always_comb
    begin
        valid_above = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (valid_reg[i] && (IDX_W'(i) > scan_idx_reg))
            begin
                valid_above = 1'b1;
            end
        end
    end

    assign free_now = cmp_live_reg && !valid_reg[cmp_idx_reg];

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        dirty_next      = dirty_reg;
        rp_next         = rp_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        cmp_live_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        victim_next     = victim_reg;
        evict_next      = evict_reg;

        load            = 1'b0;
        action_next     = ACT_NONE;
        slot_idx_next   = '0;
        sector_next     = '0;
        drv_next        = 1'b0;
        hit_next        = 1'b0;
        final_next      = 1'b0;
        done_next       = 1'b0;

        tag_wr_en       = 1'b0;
        tag_rd_en       = 1'b0;
        tag_rd_addr     = scan_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                scan_idx_next   = '0;
                issue_done_next = 1'b0;
                free_found_next = 1'b0;
                if (accept)
                begin
                    if (kind == KIND_FLUSH)
                    begin
                        state_next = ST_FL_NEXT;
                    end
                    else if (kind == KIND_READ || kind == KIND_WRITE)
                    begin
                        state_next = ST_SEARCH;
                    end
                    // unused kind: drop
                end
            end

            ST_SEARCH:
            begin
                // issue the next tag read
                if (!issue_done_reg)
                begin
                    tag_rd_en     = 1'b1;
                    cmp_live_next = 1'b1;
                    cmp_idx_next  = scan_idx_reg;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                // compare the tag read in the previous cycle
                if (cmp_live_reg)
                begin
                    if (valid_reg[cmp_idx_reg] && tag_rd_data == sec_reg)
                    begin
                        victim_next = cmp_idx_reg;
                        state_next  = ST_HIT_EMIT;
                    end
                    else
                    begin
                        if (free_now && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            // miss: first free slot, else the round-robin victim
                            if (free_found_reg)
                            begin
                                victim_next = free_idx_reg;
                                evict_next  = 1'b0;
                                state_next  = ST_FILL_EMIT;
                            end
                            else if (free_now)
                            begin
                                victim_next = cmp_idx_reg;
                                evict_next  = 1'b0;
                                state_next  = ST_FILL_EMIT;
                            end
                            else
                            begin
                                victim_next = rp_reg;
                                evict_next  = 1'b1;
                                state_next  = dirty_reg[rp_reg] ? ST_WB_READ : ST_FILL_EMIT;
                            end
                        end
                    end
                end
            end

            ST_WB_READ:
            begin
                tag_rd_en   = 1'b1;
                tag_rd_addr = victim_reg;
                state_next  = ST_WB_EMIT;
            end

            ST_WB_EMIT:
            begin
                action_next   = ACT_WRITE_BACK;
                slot_idx_next = victim_reg;
                sector_next   = tag_rd_data;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = ST_FILL_EMIT;
                end
            end

            ST_FILL_EMIT:
            begin
                action_next   = (kind_reg == KIND_READ) ? ACT_FILL : ACT_WRITE_THRU;
                slot_idx_next = victim_reg;
                sector_next   = sec_reg;
                drv_next      = req_drive_reg;
                final_next    = 1'b1;
                done_next     = last_reg;
                if (can_load)
                begin
                    load                   = 1'b1;
                    tag_wr_en              = 1'b1;
                    valid_next[victim_reg] = 1'b1;
                    dirty_next[victim_reg] = 1'b0;
                    if (evict_reg)
                    begin
                        rp_next = (rp_reg == LAST_IDX) ? '0 : rp_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_HIT_EMIT:
            begin
                action_next   = ACT_NONE;
                slot_idx_next = victim_reg;
                sector_next   = sec_reg;
                hit_next      = 1'b1;
                final_next    = 1'b1;
                done_next     = last_reg;
                if (can_load)
                begin
                    load = 1'b1;
                    if (kind_reg == KIND_WRITE)
                    begin
                        dirty_next[victim_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FL_NEXT:
            begin
                if (valid_reg[scan_idx_reg])
                begin
                    tag_rd_en  = 1'b1;
                    state_next = ST_FL_EMIT;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_FL_NONE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_FL_EMIT:
            begin
                action_next   = ACT_WRITE_BACK;
                slot_idx_next = scan_idx_reg;
                sector_next   = tag_rd_data;
                final_next    = !valid_above;
                done_next     = !valid_above && last_reg;
                if (can_load)
                begin
                    load = 1'b1;
                    if (!valid_above)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                        state_next    = ST_FL_NEXT;
                    end
                end
            end

            ST_FL_NONE:
            begin
                final_next = 1'b1;
                done_next  = last_reg;
                if (can_load)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = load ? 1'b1 : (rsp_valid_reg && rsp_stall);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            dirty_reg      <= '0;
            rp_reg         <= '0;
            scan_idx_reg   <= '0;
            issue_done_reg <= 1'b0;
            cmp_live_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            evict_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            dirty_reg      <= dirty_next;
            rp_reg         <= rp_next;
            scan_idx_reg   <= scan_idx_next;
            issue_done_reg <= issue_done_next;
            cmp_live_reg   <= cmp_live_next;
            free_found_reg <= free_found_next;
            evict_reg      <= evict_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload: request hold, scan indices and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= kind;
            sec_reg       <= sector_number;
            req_drive_reg <= drive;
            last_reg      <= last_of_request;
        end
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        victim_reg   <= victim_next;
        if (load)
        begin
            action_reg   <= action_next;
            slot_idx_reg <= slot_idx_next;
            sector_reg   <= sector_next;
            drv_reg      <= drv_next;
            hit_reg      <= hit_next;
            final_reg    <= final_next;
            done_reg     <= done_next;
        end
    end

    // report the low bits of the slot index
    assign slot_wide = {{SLOT_W{1'b0}}, slot_idx_reg};

    assign rsp_valid    = rsp_valid_reg;
    assign action       = action_reg;
    assign slot         = slot_wide[SLOT_W-1:0];
    assign disk_sector  = sector_reg;
    assign disk_drive   = drv_reg;
    assign hit          = hit_reg;
    assign final_res    = final_reg;
    assign request_done = done_reg;

endmodule
